>>> rtl/sse_diagonal_update_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the diagonal update block
// Shared forms for same-cycle and next-cycle implications.
// -----------------------------------------------------------------------------
`ifndef SSE_DIAGONAL_UPDATE_MACROS_SVH
`define SSE_DIAGONAL_UPDATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sse_diagonal_update: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sse_diagonal_update: check failed");

`endif

>>> rtl/sse_du_pkg.sv
// -----------------------------------------------------------------------------
// sse_du_pkg
// Types and constants of the diagonal update block.
// -----------------------------------------------------------------------------
package sse_du_pkg;

   localparam int MAX_SPINS = 1024;
   localparam int MAX_BONDS = 1024;
   localparam int MAX_OPS   = 4096;
   localparam int FRAC_BITS = 16;

   localparam int SPIN_AW = $clog2(MAX_SPINS);
   localparam int BOND_AW = $clog2(MAX_BONDS);
   localparam int CNT_W   = 13;
   localparam int NUM_W   = 11;
   localparam int CFG_W   = 24;
   localparam int UNI_W   = 16;
   localparam int CSR_IW  = 3;

   // Shared multiplier: one 32 x 24 product per cycle, wide operands in chunks.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 96;
   localparam int X_W     = 64;
   localparam logic [1:0] LAST_CHUNK = 2'd2;
   localparam logic [1:0] LAST_OP    = 2'd2;

   localparam logic [UNI_W-1:0] HALF_Q16 = 16'h8000;

   localparam logic [CSR_IW-1:0] CSR_NUM_SPINS = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_NUM_BONDS = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_CUTOFF    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_INV_TEMP  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_FIELD     = 3'd4;

   typedef enum logic [1:0] {
      ACT_SPIN   = 2'd0,
      ACT_BOND   = 2'd1,
      ACT_START  = 2'd2,
      ACT_UPDATE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_IDENT   = 2'd0,
      KIND_DBOND   = 2'd1,
      KIND_DFIELD  = 2'd2,
      KIND_OFFDIAG = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      T_BOND_INS  = 2'd0,
      T_FIELD_INS = 2'd1,
      T_BOND_REM  = 2'd2,
      T_FIELD_REM = 2'd3
   } test_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PICK,
      ST_BOND_RD,
      ST_SPIN_A,
      ST_SPIN_B,
      ST_SPIN_CHK,
      ST_MUL,
      ST_CMP,
      ST_FLIP_RD,
      ST_FLIP_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SPIN_AW-1:0] site_a;
      logic [SPIN_AW-1:0] site_b;
      logic signed [7:0]  coupling;
   } bond_entry_type;

endpackage

>>> rtl/sse_du_req_if.sv
// -----------------------------------------------------------------------------
// sse_du_req_if
// Request channel: load, start and update items.
// -----------------------------------------------------------------------------
interface sse_du_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [9:0]        table_index;
   logic              spin_up;
   logic [9:0]        site_a;
   logic [9:0]        site_b;
   logic signed [7:0] coupling;
   logic [12:0]       start_count;
   logic [1:0]        op_kind;
   logic [9:0]        op_target;
   logic [15:0]       coin_u;
   logic [15:0]       pick_u;
   logic [15:0]       accept_u;

   modport source (output valid, action, table_index, spin_up, site_a, site_b, coupling,
                   start_count, op_kind, op_target, coin_u, pick_u, accept_u,
                   input ready);
   modport sink (input valid, action, table_index, spin_up, site_a, site_b, coupling,
                 start_count, op_kind, op_target, coin_u, pick_u, accept_u,
                 output ready);
endinterface

>>> rtl/sse_du_rsp_if.sv
// -----------------------------------------------------------------------------
// sse_du_rsp_if
// Response channel: one result item per request item.
// -----------------------------------------------------------------------------
interface sse_du_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  new_kind;
   logic [9:0]  new_target;
   logic [12:0] operator_count;
   logic        changed;

   modport source (output valid, new_kind, new_target, operator_count, changed,
                   input ready);
   modport sink (input valid, new_kind, new_target, operator_count, changed,
                 output ready);
endinterface

>>> rtl/sse_diagonal_update.sv
// -----------------------------------------------------------------------------
// sse_diagonal_update
// Diagonal Metropolis update of a transverse-field Ising operator string.
// -----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   req_chan  in         action, table loads, start count, string entry, uniforms
//   rsp_chan  out        new kind, new target, operator count, changed flag
//   csr_*     in         write enable, register index, write data
//
// One 32 x 24 multiplier is shared: each of the three factors of an acceptance
// test goes through it in three chunks. No new item is taken until the result
// item has been taken. Reset is synchronous; the tables are not cleared and
// must be loaded before use.
// -----------------------------------------------------------------------------
module sse_diagonal_update (
   input  logic               clock,
   input  logic               reset,
   sse_du_req_if.sink         req_chan,
   sse_du_rsp_if.source       rsp_chan,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   // Configuration registers.
   logic [sse_du_pkg::NUM_W-1:0] num_spins_ff, num_bonds_ff;
   logic [sse_du_pkg::CNT_W-1:0] cutoff_ff;
   logic [sse_du_pkg::CFG_W-1:0] inv_temp_ff, field_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_spins_ff <= sse_du_pkg::NUM_W'(sse_du_pkg::MAX_SPINS);
         num_bonds_ff <= sse_du_pkg::NUM_W'(sse_du_pkg::MAX_BONDS);
         cutoff_ff    <= sse_du_pkg::CNT_W'(sse_du_pkg::MAX_OPS);
         inv_temp_ff  <= sse_du_pkg::CFG_W'(65536);
         field_ff     <= sse_du_pkg::CFG_W'(65536);
      end else if (csr_write_en) begin
         case (csr_index)
            sse_du_pkg::CSR_NUM_SPINS: num_spins_ff <= csr_wdata[sse_du_pkg::NUM_W-1:0];
            sse_du_pkg::CSR_NUM_BONDS: num_bonds_ff <= csr_wdata[sse_du_pkg::NUM_W-1:0];
            sse_du_pkg::CSR_CUTOFF:    cutoff_ff    <= csr_wdata[sse_du_pkg::CNT_W-1:0];
            sse_du_pkg::CSR_INV_TEMP:  inv_temp_ff  <= csr_wdata;
            sse_du_pkg::CSR_FIELD:     field_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective sizes, clamped to the supported range.
   logic [sse_du_pkg::NUM_W-1:0] ns, nb;
   logic [sse_du_pkg::CNT_W-1:0] len;

   always_comb begin
      if (num_spins_ff == '0) ns = sse_du_pkg::NUM_W'(1);
      else if (num_spins_ff > sse_du_pkg::NUM_W'(sse_du_pkg::MAX_SPINS))
         ns = sse_du_pkg::NUM_W'(sse_du_pkg::MAX_SPINS);
      else ns = num_spins_ff;
      if (num_bonds_ff == '0) nb = sse_du_pkg::NUM_W'(1);
      else if (num_bonds_ff > sse_du_pkg::NUM_W'(sse_du_pkg::MAX_BONDS))
         nb = sse_du_pkg::NUM_W'(sse_du_pkg::MAX_BONDS);
      else nb = num_bonds_ff;
      if (cutoff_ff == '0) len = sse_du_pkg::CNT_W'(1);
      else if (cutoff_ff > sse_du_pkg::CNT_W'(sse_du_pkg::MAX_OPS))
         len = sse_du_pkg::CNT_W'(sse_du_pkg::MAX_OPS);
      else len = cutoff_ff;
   end

   // Control and datapath registers.
   sse_du_pkg::state_type            state_ff, state_in;
   sse_du_pkg::test_type             test_ff, test_in;
   logic [1:0]                       ch_ff, ch_in, op_ff, op_in;
   logic [sse_du_pkg::ACC_W-1:0]     p_ff, p_in, r_ff, r_in;
   logic [sse_du_pkg::X_W-1:0]       x_ff, x_in;
   logic [sse_du_pkg::BOND_AW-1:0]   idx_ff, idx_in;
   logic [9:0]                       tgt_ff, tgt_in;
   logic [sse_du_pkg::UNI_W-1:0]     u_ff, u_in;
   logic                             s1_ff, s1_in;
   logic [sse_du_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [1:0]                       kind_ff, kind_in;
   logic [9:0]                       target_ff, target_in;
   logic                             changed_ff, changed_in;

   // Table memories with registered read data.
   logic                             spin_mem [sse_du_pkg::MAX_SPINS];
   sse_du_pkg::bond_entry_type       bond_mem [sse_du_pkg::MAX_BONDS];
   logic                             spin_q_ff;
   sse_du_pkg::bond_entry_type       bond_q_ff;
   logic                             spin_we, spin_wd;
   logic [sse_du_pkg::SPIN_AW-1:0]   spin_wa, spin_ra;
   logic                             bond_we;
   logic [sse_du_pkg::BOND_AW-1:0]   bond_wa, bond_ra;
   sse_du_pkg::bond_entry_type       bond_wd;

   always_ff @(posedge clock) begin
      if (spin_we) spin_mem[spin_wa] <= spin_wd;
      spin_q_ff <= spin_mem[spin_ra];
   end

   always_ff @(posedge clock) begin
      if (bond_we) bond_mem[bond_wa] <= bond_wd;
      bond_q_ff <= bond_mem[bond_ra];
   end

   // Shared multiplier.
   logic [sse_du_pkg::MUL_A_W-1:0]   mul_a;
   logic [sse_du_pkg::MUL_B_W-1:0]   mul_b;
   logic [sse_du_pkg::MUL_P_W-1:0]   mul_p;
   logic [sse_du_pkg::ACC_W-1:0]     part_sh, acc;

   assign mul_p   = mul_a * mul_b;
   assign part_sh = sse_du_pkg::ACC_W'(mul_p) << {ch_ff, 5'b0};
   assign acc     = ((ch_ff == 2'd0) ? '0 : r_ff) + part_sh;

   // Quantities derived from the count and the bond read.
   logic [sse_du_pkg::CNT_W-1:0]     m_val, m_inc;
   logic [7:0]                       mag;
   logic                             is_bond, is_ins, accepted;
   logic [sse_du_pkg::ACC_W-1:0]     rhs;

   assign m_val   = (len > count_ff) ? len - count_ff : '0;
   assign m_inc   = m_val + sse_du_pkg::CNT_W'(1);
   assign mag     = bond_q_ff.coupling[7] ? 8'(-bond_q_ff.coupling) : bond_q_ff.coupling;
   assign is_bond = (test_ff == sse_du_pkg::T_BOND_INS) || (test_ff == sse_du_pkg::T_BOND_REM);
   assign is_ins  = (test_ff == sse_du_pkg::T_BOND_INS) || (test_ff == sse_du_pkg::T_FIELD_INS);

   // Right side of the acceptance test and the compare itself.
   always_comb begin
      case (test_ff)
         sse_du_pkg::T_BOND_INS:  rhs = sse_du_pkg::ACC_W'(x_ff);
         sse_du_pkg::T_FIELD_INS: rhs = sse_du_pkg::ACC_W'(x_ff);
         sse_du_pkg::T_BOND_REM:
            rhs = sse_du_pkg::ACC_W'(m_inc) << (1 + sse_du_pkg::FRAC_BITS + 16);
         default:
            rhs = sse_du_pkg::ACC_W'(m_inc) << (2 * sse_du_pkg::FRAC_BITS + 16);
      endcase
      if (test_ff == sse_du_pkg::T_FIELD_INS)
         accepted = (p_ff << sse_du_pkg::FRAC_BITS) < rhs;
      else
         accepted = p_ff < rhs;
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sse_du_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      test_ff    <= test_in;
      ch_ff      <= ch_in;
      op_ff      <= op_in;
      p_ff       <= p_in;
      r_ff       <= r_in;
      x_ff       <= x_in;
      idx_ff     <= idx_in;
      tgt_ff     <= tgt_in;
      u_ff       <= u_in;
      s1_ff      <= s1_in;
      kind_ff    <= kind_in;
      target_ff  <= target_in;
      changed_ff <= changed_in;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      test_in    = test_ff;
      ch_in      = ch_ff;
      op_in      = op_ff;
      p_in       = p_ff;
      r_in       = r_ff;
      x_in       = x_ff;
      idx_in     = idx_ff;
      tgt_in     = tgt_ff;
      u_in       = u_ff;
      s1_in      = s1_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      target_in  = target_ff;
      changed_in = changed_ff;
      spin_we    = 1'b0;
      spin_wa    = tgt_ff;
      spin_wd    = ~spin_q_ff;
      spin_ra    = tgt_ff;
      bond_we    = 1'b0;
      bond_wa    = req_chan.table_index;
      bond_wd    = {req_chan.site_a, req_chan.site_b, req_chan.coupling};
      bond_ra    = (test_ff == sse_du_pkg::T_BOND_INS) ? idx_ff : tgt_ff;
      mul_a      = p_ff[sse_du_pkg::MUL_A_W-1:0];
      mul_b      = sse_du_pkg::MUL_B_W'(is_bond ? nb : ns);

      case (state_ff)
         sse_du_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in    = sse_du_pkg::KIND_IDENT;
               target_in  = '0;
               changed_in = 1'b0;
               tgt_in     = req_chan.op_target;
               u_in       = req_chan.accept_u;
               ch_in      = '0;
               op_in      = '0;
               state_in   = sse_du_pkg::ST_DONE;
               case (sse_du_pkg::action_type'(req_chan.action))
                  sse_du_pkg::ACT_SPIN: begin
                     spin_we = 1'b1;
                     spin_wa = req_chan.table_index;
                     spin_wd = req_chan.spin_up;
                  end
                  sse_du_pkg::ACT_BOND: begin
                     bond_we = 1'b1;
                  end
                  sse_du_pkg::ACT_START: begin
                     count_in = (req_chan.start_count > len) ? len : req_chan.start_count;
                  end
                  default: begin
                     case (sse_du_pkg::kind_type'(req_chan.op_kind))
                        sse_du_pkg::KIND_IDENT: begin
                           if (count_ff < len) begin
                              p_in     = sse_du_pkg::ACC_W'(req_chan.pick_u);
                              test_in  = (req_chan.coin_u < sse_du_pkg::HALF_Q16) ?
                                         sse_du_pkg::T_BOND_INS : sse_du_pkg::T_FIELD_INS;
                              state_in = sse_du_pkg::ST_PICK;
                           end
                        end
                        sse_du_pkg::KIND_DBOND: begin
                           p_in     = sse_du_pkg::ACC_W'(inv_temp_ff);
                           test_in  = sse_du_pkg::T_BOND_REM;
                           state_in = sse_du_pkg::ST_BOND_RD;
                        end
                        sse_du_pkg::KIND_DFIELD: begin
                           p_in     = sse_du_pkg::ACC_W'(inv_temp_ff);
                           test_in  = sse_du_pkg::T_FIELD_REM;
                           state_in = sse_du_pkg::ST_MUL;
                        end
                        default: begin
                           state_in = sse_du_pkg::ST_FLIP_RD;
                        end
                     endcase
                  end
               endcase
            end
         end

         // Index pick: (pick_u times the size) shifted right by 16.
         sse_du_pkg::ST_PICK: begin
            idx_in   = mul_p[16 +: sse_du_pkg::BOND_AW];
            p_in     = sse_du_pkg::ACC_W'(inv_temp_ff);
            state_in = is_bond ? sse_du_pkg::ST_BOND_RD : sse_du_pkg::ST_MUL;
         end

         sse_du_pkg::ST_BOND_RD: begin
            state_in = (test_ff == sse_du_pkg::T_BOND_INS) ?
                       sse_du_pkg::ST_SPIN_A : sse_du_pkg::ST_MUL;
         end

         sse_du_pkg::ST_SPIN_A: begin
            spin_ra  = bond_q_ff.site_a;
            state_in = sse_du_pkg::ST_SPIN_B;
         end

         sse_du_pkg::ST_SPIN_B: begin
            s1_in    = spin_q_ff;
            spin_ra  = bond_q_ff.site_b;
            state_in = sse_du_pkg::ST_SPIN_CHK;
         end

         // A bond may go in only where its energy is favorable.
         sse_du_pkg::ST_SPIN_CHK: begin
            if (mag != 8'd0 && (!bond_q_ff.coupling[7]) == (s1_ff == spin_q_ff))
               state_in = sse_du_pkg::ST_MUL;
            else
               state_in = sse_du_pkg::ST_DONE;
         end

         // Three factor passes, each three chunks of the running product.
         sse_du_pkg::ST_MUL: begin
            mul_a = p_ff[{ch_ff, 5'b0} +: sse_du_pkg::MUL_A_W];
            case (op_ff)
               2'd0: mul_b = sse_du_pkg::MUL_B_W'(is_bond ? nb : ns);
               2'd1: mul_b = is_bond ? sse_du_pkg::MUL_B_W'(mag) : field_ff;
               default: begin
                  if (!is_ins) mul_b = sse_du_pkg::MUL_B_W'(u_ff);
                  else if (is_bond) mul_b = sse_du_pkg::MUL_B_W'({m_val, 1'b0});
                  else mul_b = sse_du_pkg::MUL_B_W'(m_val);
               end
            endcase
            if (ch_ff == sse_du_pkg::LAST_CHUNK) begin
               ch_in = '0;
               if (op_ff == 2'd1) begin
                  x_in = acc[sse_du_pkg::X_W-1:0];
                  p_in = is_ins ? sse_du_pkg::ACC_W'(u_ff) : acc;
               end else begin
                  p_in = acc;
               end
               if (op_ff == sse_du_pkg::LAST_OP) state_in = sse_du_pkg::ST_CMP;
               else op_in = op_ff + 2'd1;
            end else begin
               r_in  = acc;
               ch_in = ch_ff + 2'd1;
            end
         end

         sse_du_pkg::ST_CMP: begin
            state_in = sse_du_pkg::ST_DONE;
            if (is_ins) begin
               if (accepted) begin
                  kind_in    = is_bond ? sse_du_pkg::KIND_DBOND : sse_du_pkg::KIND_DFIELD;
                  target_in  = idx_ff;
                  changed_in = 1'b1;
                  count_in   = count_ff + sse_du_pkg::CNT_W'(1);
               end
            end else if (accepted) begin
               changed_in = 1'b1;
               if (count_ff != '0) count_in = count_ff - sse_du_pkg::CNT_W'(1);
            end else begin
               kind_in   = is_bond ? sse_du_pkg::KIND_DBOND : sse_du_pkg::KIND_DFIELD;
               target_in = tgt_ff;
            end
         end

         sse_du_pkg::ST_FLIP_RD: begin
            state_in = sse_du_pkg::ST_FLIP_WR;
         end

         // Off-diagonal entry: write back the flipped spin.
         sse_du_pkg::ST_FLIP_WR: begin
            spin_we   = 1'b1;
            kind_in   = sse_du_pkg::KIND_OFFDIAG;
            target_in = tgt_ff;
            state_in  = sse_du_pkg::ST_DONE;
         end

         sse_du_pkg::ST_DONE: begin
            if (rsp_chan.ready) state_in = sse_du_pkg::ST_IDLE;
         end

         default: begin
            state_in = sse_du_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake and result item.
   assign req_chan.ready          = (state_ff == sse_du_pkg::ST_IDLE);
   assign rsp_chan.valid          = (state_ff == sse_du_pkg::ST_DONE);
   assign rsp_chan.new_kind       = kind_ff;
   assign rsp_chan.new_target     = target_ff;
   assign rsp_chan.operator_count = count_ff;
   assign rsp_chan.changed        = changed_ff;

endmodule

>>> rtl/sse_du_chk.sv
// -----------------------------------------------------------------------------
// sse_du_chk
// Port-level checks of the diagonal update block, bound to its top level.
// -----------------------------------------------------------------------------
`include "sse_diagonal_update_macros.svh"

module sse_du_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_new_kind,
   input logic [12:0] rsp_operator_count,
   input logic        rsp_changed
);

   // A pending result blocks new items.
   `SSE_ASSERT_NOW(a_busy_while_result, rsp_valid, !req_ready)

   // In the cycle after an item is taken, the block is busy.
   `SSE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // The count never exceeds the longest string.
   `SSE_ASSERT_NOW(a_count_bound, rsp_valid,
                   rsp_operator_count <= 13'(sse_du_pkg::MAX_OPS))

   // A stalled result item holds its count, kind and changed flag.
   `SSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_operator_count) && $stable(rsp_new_kind)
                    && $stable(rsp_changed))

endmodule

bind sse_diagonal_update sse_du_chk u_sse_du_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_new_kind       (rsp_chan.new_kind),
   .rsp_operator_count (rsp_chan.operator_count),
   .rsp_changed        (rsp_chan.changed)
);
